FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the filter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked on every rising clock edge out of reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property that must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rstn, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) trig |=> prop) else $error(msg);

`endif

FILE: hw/rtl/mmwf_pkg.sv
// Shared constants, types and helper functions of the window filter.
`default_nettype none
package mmwf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_RADIUS  = 3;
    localparam int WIN_SIDE    = 2 * MAX_RADIUS + 1;
    localparam int WIN_AREA    = WIN_SIDE * WIN_SIDE;
    localparam int STORE_DEPTH = (2 * MAX_RADIUS + 2) * MAX_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int TAP_W       = $clog2(WIN_AREA);
    localparam int RECIP_SHIFT = 20;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_RADIUS = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;

    typedef logic [2:0][7:0] pix_t;

    typedef struct packed {
        pix_t       val;
        logic [2:0] full;
        logic [2:0] keep;
    } mmwf_link_t;

    function automatic logic [TAP_W-1:0] win_count(input logic [1:0] r);
        case (r)
            2'd0:    win_count = TAP_W'(1);
            2'd1:    win_count = TAP_W'(9);
            2'd2:    win_count = TAP_W'(25);
            default: win_count = TAP_W'(49);
        endcase
    endfunction

    function automatic logic [TAP_W-1:0] med_idx(input logic [1:0] r);
        case (r)
            2'd0:    med_idx = TAP_W'(0);
            2'd1:    med_idx = TAP_W'(4);
            2'd2:    med_idx = TAP_W'(12);
            default: med_idx = TAP_W'(24);
        endcase
    endfunction

    // Rounded-up reciprocal of the window area, scaled by two to the RECIP_SHIFT.
    function automatic logic [RECIP_SHIFT:0] recip(input logic [1:0] r);
        case (r)
            2'd0:    recip = 21'd1048576;
            2'd1:    recip = 21'd116509;
            2'd2:    recip = 21'd41944;
            default: recip = 21'd21400;
        endcase
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/mmwf_cell.sv
// One insertion-sort cell holding one sorted value for each color channel.
`default_nettype none
module mmwf_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               clear,
    input  wire logic               shift,
    input  wire mmwf_pkg::pix_t     x,
    input  wire mmwf_pkg::mmwf_link_t prev,
    output mmwf_pkg::mmwf_link_t    link
);
    import mmwf_pkg::*;

    pix_t       val_reg;
    logic [2:0] full_reg;
    logic [2:0] keep;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            keep[c] = full_reg[c] && (val_reg[c] <= x[c]);
        end
    end

    assign link.val  = val_reg;
    assign link.full = full_reg;
    assign link.keep = keep;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= '0;
        end else if (clear) begin
            full_reg <= '0;
        end else if (shift) begin
            for (int c = 0; c < 3; c++) begin
                if (!keep[c]) begin
                    full_reg[c] <= prev.keep[c] ? 1'b1 : prev.full[c];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            for (int c = 0; c < 3; c++) begin
                if (!keep[c]) begin
                    val_reg[c] <= prev.keep[c] ? x[c] : prev.val[c];
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/mmwf_chain.sv
// Row of sort cells that keeps the window values in ascending order.
`default_nettype none
module mmwf_chain (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           clear,
    input  wire logic           shift,
    input  wire mmwf_pkg::pix_t x,
    output mmwf_pkg::pix_t      taps [mmwf_pkg::WIN_AREA]
);
    import mmwf_pkg::*;

    mmwf_link_t links [WIN_AREA+1];

    assign links[0].val  = '0;
    assign links[0].full = 3'b111;
    assign links[0].keep = 3'b111;

    for (genvar i = 0; i < WIN_AREA; i++) begin : g_cell
        mmwf_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .clear   (clear),
            .shift   (shift),
            .x       (x),
            .prev    (links[i]),
            .link    (links[i+1])
        );
        assign taps[i] = links[i+1].val;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/mean_median_window_filter.sv
// Top level of the RGB window mean and median filter.
// A beat with no output pixel leaves the block idle; a beat with an output runs the
// gather, drain, multiply and output states. The window is read from the line store
// one pixel per cycle over its single read port into the sort chain and the sum
// accumulators, the multiply state scales the sum and the output state loads the
// output register. Outputs lag the input by R*W+R pixels; flush beats drain the rest.
`default_nettype none
`include "assert_macros.svh"
module mean_median_window_filter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [7:0]  s_blue_in,
    input  wire logic [7:0]  s_green_in,
    input  wire logic [7:0]  s_red_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_blue_out,
    output logic [7:0]       m_green_out,
    output logic [7:0]       m_red_out,
    output logic             m_frame_end
);
    import mmwf_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_GATHER, S_DRAIN, S_MUL, S_OUT} state_t;

    state_t      state_reg;
    logic        mode_reg;
    logic [1:0]  radius_reg;
    logic [10:0] width_reg, height_reg;
    logic [10:0] in_row_reg, in_col_reg, out_row_reg, out_col_reg;
    logic [20:0] in_lin_reg, out_lin_reg;
    logic [12:0] y_reg, x_reg, xs_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [2:0]  dx_reg;
    logic [TAP_W-1:0] k_reg;
    logic        last_reg, feed_v_reg, in_bounds_d_reg, m_valid_reg;
    pix_t        rd_data_reg;
    logic [13:0] sum_reg [3];
    logic [34:0] prod_reg [3];
    logic [23:0] store [STORE_DEPTH];

    logic [10:0] w_eff, h_eff;
    logic [12:0] rw, lag;
    logic [TAP_W-1:0] cnt;
    logic        in_done, accept, is_pix, emit, last, issue, in_bounds;
    pix_t        feed_x;
    pix_t        taps [WIN_AREA];

    assign w_eff = (width_reg == 11'd0) ? 11'd1 :
                   (width_reg > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg == 11'd0) ? 11'd1 : height_reg;
    assign rw    = 13'(radius_reg) * 13'(w_eff);
    assign lag   = rw + 13'(radius_reg);
    assign cnt   = win_count(radius_reg);

    assign s_ready = (state_reg == S_IDLE) && !cfg_wr_en;
    assign m_valid = m_valid_reg;
    assign in_done = (in_row_reg >= h_eff);
    assign accept  = s_valid && s_ready;
    assign is_pix  = !in_done && !s_operation;
    assign emit    = accept && (in_done ? (out_row_reg < h_eff) :
                     (is_pix && ({1'b0, in_lin_reg} + 22'd1 >
                                 {1'b0, out_lin_reg} + 22'(lag))));
    assign last    = (out_row_reg == h_eff - 11'd1) && (out_col_reg == w_eff - 11'd1);
    assign issue   = (state_reg == S_GATHER);
    assign in_bounds = !y_reg[12] && (y_reg[11:0] < {1'b0, h_eff}) &&
                       !x_reg[12] && (x_reg[11:0] < {1'b0, w_eff});
    assign feed_x  = in_bounds_d_reg ? rd_data_reg : '0;

    mmwf_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (emit),
        .shift   (feed_v_reg),
        .x       (feed_x),
        .taps    (taps)
    );

    always_ff @(posedge aclk) begin
        if (accept && is_pix) begin
            store[in_lin_reg[ADDR_W-1:0]] <= {s_red_in, s_green_in, s_blue_in};
        end
        if (issue) begin
            rd_data_reg <= store[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        in_bounds_d_reg <= in_bounds;
        for (int c = 0; c < 3; c++) begin
            if (emit) begin
                sum_reg[c] <= '0;
            end else if (feed_v_reg) begin
                sum_reg[c] <= sum_reg[c] + 14'(feed_x[c]);
            end
            if (state_reg == S_MUL) begin
                prod_reg[c] <= 35'(sum_reg[c]) * 35'(recip(radius_reg));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mode_reg    <= 1'b0;
            radius_reg  <= 2'd1;
            width_reg   <= 11'd640;
            height_reg  <= 11'd480;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            in_lin_reg  <= '0;
            out_lin_reg <= '0;
            feed_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
        end else begin
            feed_v_reg <= issue;
            if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
                m_blue_out  <= mode_reg ? taps[med_idx(radius_reg)][0] : prod_reg[0][27:20];
                m_green_out <= mode_reg ? taps[med_idx(radius_reg)][1] : prod_reg[1][27:20];
                m_red_out   <= mode_reg ? taps[med_idx(radius_reg)][2] : prod_reg[2][27:20];
                m_frame_end <= last_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (cfg_wr_en) begin
                        case (cfg_index)
                            CFG_MODE:   mode_reg   <= cfg_data[0];
                            CFG_RADIUS: radius_reg <= cfg_data[1:0];
                            CFG_WIDTH:  width_reg  <= cfg_data;
                            CFG_HEIGHT: height_reg <= cfg_data;
                            default:    mode_reg   <= mode_reg;
                        endcase
                        in_row_reg  <= '0;
                        in_col_reg  <= '0;
                        out_row_reg <= '0;
                        out_col_reg <= '0;
                        in_lin_reg  <= '0;
                        out_lin_reg <= '0;
                    end else if (emit && last) begin
                        in_row_reg  <= '0;
                        in_col_reg  <= '0;
                        out_row_reg <= '0;
                        out_col_reg <= '0;
                        in_lin_reg  <= '0;
                        out_lin_reg <= '0;
                    end else begin
                        if (accept && is_pix) begin
                            in_lin_reg <= in_lin_reg + 21'd1;
                            if (in_col_reg + 11'd1 >= w_eff) begin
                                in_col_reg <= '0;
                                in_row_reg <= in_row_reg + 11'd1;
                            end else begin
                                in_col_reg <= in_col_reg + 11'd1;
                            end
                        end
                        if (emit) begin
                            out_lin_reg <= out_lin_reg + 21'd1;
                            if (out_col_reg + 11'd1 >= w_eff) begin
                                out_col_reg <= '0;
                                out_row_reg <= out_row_reg + 11'd1;
                            end else begin
                                out_col_reg <= out_col_reg + 11'd1;
                            end
                        end
                    end
                    if (emit) begin
                        y_reg     <= {2'b00, out_row_reg} - 13'(radius_reg);
                        x_reg     <= {2'b00, out_col_reg} - 13'(radius_reg);
                        xs_reg    <= {2'b00, out_col_reg} - 13'(radius_reg);
                        addr_reg  <= out_lin_reg[ADDR_W-1:0] - ADDR_W'(lag);
                        last_reg  <= last;
                        dx_reg    <= '0;
                        k_reg     <= '0;
                        state_reg <= S_GATHER;
                    end
                end
                S_GATHER: begin
                    k_reg <= k_reg + TAP_W'(1);
                    if (dx_reg == {radius_reg, 1'b0}) begin
                        dx_reg   <= '0;
                        x_reg    <= xs_reg;
                        y_reg    <= y_reg + 13'd1;
                        addr_reg <= addr_reg + ADDR_W'(w_eff) - ADDR_W'({radius_reg, 1'b0});
                    end else begin
                        dx_reg   <= dx_reg + 3'd1;
                        x_reg    <= x_reg + 13'd1;
                        addr_reg <= addr_reg + ADDR_W'(1);
                    end
                    if (k_reg == cnt - TAP_W'(1)) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: state_reg <= S_MUL;
                S_MUL:   state_reg <= S_OUT;
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_gather_count, aclk, aresetn, (state_reg == S_GATHER) |-> (k_reg < cnt), "window read count overrun")
    `ASSERT_NEXT(a_out_from_out_state, aclk, aresetn, !m_valid_reg, !m_valid_reg || ($past(state_reg) == S_OUT), "output loaded outside the output state")
    `ASSERT_CLK(a_med_stable, aclk, aresetn, (state_reg == S_OUT) |-> !feed_v_reg, "sort chain still shifting at output")

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the RGB window mean and median filter.
`timescale 1ns / 100ps
module testbench;
    import mmwf_pkg::*;

    localparam int LIMIT_CYCLES = 4000000;
    localparam int SETTLE = 60;

    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       last;
    } filt_pixel_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_operation;
    logic [7:0]  s_blue_in;
    logic [7:0]  s_green_in;
    logic [7:0]  s_red_in;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_blue_out;
    logic [7:0]  m_green_out;
    logic [7:0]  m_red_out;
    logic        m_frame_end;

    mean_median_window_filter dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_blue_in(s_blue_in), .s_green_in(s_green_in), .s_red_in(s_red_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_blue_out(m_blue_out), .m_green_out(m_green_out),
        .m_red_out(m_red_out), .m_frame_end(m_frame_end)
    );

    // Filter state mirrored on the testbench side.
    logic        mdl_mode;
    logic [1:0]  mdl_radius;
    logic [10:0] mdl_width;
    logic [10:0] mdl_height;
    logic [23:0] pix_mem [STORE_DEPTH];
    int          in_row, in_col, out_row, out_col;

    filt_pixel_t pending_pixels[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          calm = 0;
    bit          hold_req = 0;
    int          hold_left = 0;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic int eff_width();
        if (mdl_width == 0) return 1;
        if (mdl_width > MAX_WIDTH) return MAX_WIDTH;
        return mdl_width;
    endfunction

    function automatic int eff_height();
        return (mdl_height == 0) ? 1 : mdl_height;
    endfunction

    function automatic int eff_radius();
        return (mdl_radius > MAX_RADIUS) ? MAX_RADIUS : mdl_radius;
    endfunction

    function automatic void clear_position();
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
    endfunction

    function automatic logic [7:0] filter_channel(int vals[], int cnt);
        int sum;
        int tmp;
        int j;
        sum = 0;
        for (int i = 0; i < cnt; i++) sum += vals[i];
        if (mdl_mode == 1'b0) return 8'(sum / cnt);
        for (int i = 1; i < cnt; i++) begin
            tmp = vals[i];
            j = i;
            while (j > 0 && vals[j - 1] > tmp) begin
                vals[j] = vals[j - 1];
                j--;
            end
            vals[j] = tmp;
        end
        return 8'(vals[cnt / 2]);
    endfunction

    function automatic void push_window_result();
        int w, h, r, cnt, y, x;
        logic [23:0] p;
        int vb[], vg[], vr[];
        filt_pixel_t res;
        w = eff_width();
        h = eff_height();
        r = eff_radius();
        cnt = (2 * r + 1) * (2 * r + 1);
        vb = new[cnt];
        vg = new[cnt];
        vr = new[cnt];
        cnt = 0;
        for (int dy = -r; dy <= r; dy++) begin
            for (int dx = -r; dx <= r; dx++) begin
                y = out_row + dy;
                x = out_col + dx;
                p = 24'd0;
                if (y >= 0 && y < h && x >= 0 && x < w) p = pix_mem[(y * w + x) % STORE_DEPTH];
                vb[cnt] = p[7:0];
                vg[cnt] = p[15:8];
                vr[cnt] = p[23:16];
                cnt++;
            end
        end
        res.blue = filter_channel(vb, cnt);
        res.green = filter_channel(vg, cnt);
        res.red = filter_channel(vr, cnt);
        res.last = (out_row == h - 1) && (out_col == w - 1);
        pending_pixels.push_back(res);
        if (res.last) begin
            clear_position();
        end else if (out_col + 1 >= w) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
    endfunction

    function automatic void predict_beat(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r);
        int w, h, lag, received, emitted;
        w = eff_width();
        h = eff_height();
        lag = eff_radius() * w + eff_radius();
        if (in_row >= h) begin
            if (out_row < h) push_window_result();
            return;
        end
        if (op) return;
        received = in_row * w + in_col;
        emitted = out_row * w + out_col;
        pix_mem[received % STORE_DEPTH] = {r, g, b};
        received++;
        if (in_col + 1 >= w) begin
            in_col = 0;
            in_row++;
        end else begin
            in_col++;
        end
        if (received > emitted + lag) push_window_result();
    endfunction

    task automatic send_beat(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r);
        while (!calm && $urandom_range(99) < 36) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_blue_in <= b;
        s_green_in <= g;
        s_red_in <= r;
        do @(posedge aclk); while (!s_ready);
        predict_beat(op, b, g, r);
    endtask

    task automatic send_random_pixel();
        send_beat(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] value);
        wait_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_MODE:   mdl_mode = value[0];
            CFG_RADIUS: mdl_radius = value[1:0];
            CFG_WIDTH:  mdl_width = value;
            CFG_HEIGHT: mdl_height = value;
            default:    mdl_mode = mdl_mode;
        endcase
        clear_position();
    endtask

    task automatic setup(logic mode, logic [1:0] rad, logic [10:0] w, logic [10:0] h);
        write_reg(CFG_MODE, 11'(mode));
        write_reg(CFG_RADIUS, 11'(rad));
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    task automatic flush_frame(int extra);
        repeat (eff_radius() * eff_width() + eff_radius() + extra) send_beat(1'b1, 8'hA5, 8'h5A, 8'hFF);
    endtask

    task automatic send_frame(int noise_pct);
        for (int i = 0; i < eff_width() * eff_height(); i++) begin
            if ($urandom_range(99) < noise_pct) send_beat(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
            send_random_pixel();
        end
        flush_frame($urandom_range(0, 2));
    endtask

    task automatic test_directed_small();
        setup(1'b0, 2'd1, 11'd3, 11'd2);
        send_beat(1'b1, 8'hFF, 8'hFF, 8'hFF);
        send_beat(1'b0, 8'hFF, 8'hFF, 8'hFF);
        send_beat(1'b0, 8'h00, 8'h00, 8'h00);
        send_beat(1'b0, 8'hFF, 8'h00, 8'hFF);
        send_beat(1'b1, 8'h00, 8'h00, 8'h00);
        send_beat(1'b0, 8'h00, 8'hFF, 8'h00);
        send_beat(1'b0, 8'hFF, 8'hFF, 8'hFF);
        send_beat(1'b0, 8'h80, 8'h7F, 8'h01);
        send_beat(1'b0, 8'h11, 8'h22, 8'h33);
        send_beat(1'b1, 8'h00, 8'h00, 8'h00);
        send_beat(1'b1, 8'h00, 8'h00, 8'h00);
        send_beat(1'b1, 8'h00, 8'h00, 8'h00);
        write_reg(CFG_MODE, 11'd1);
        repeat (6) send_beat(1'b0, 8'hFF, 8'h00, 8'h80);
        flush_frame(1);
    endtask

    task automatic test_odd_registers();
        setup(1'b1, 2'd0, 11'd0, 11'd0);
        send_beat(1'b0, 8'h12, 8'h34, 8'h56);
        send_beat(1'b0, 8'h9A, 8'hBC, 8'hDE);
        setup(1'b0, 2'd3, 11'd5, 11'd4);
        repeat (9) send_random_pixel();
        setup(1'b1, 2'd3, 11'd5, 11'd4);
        send_frame(0);
    endtask

    task automatic test_large_sizes();
        setup(1'b1, 2'd0, 11'd2047, 11'd2);
        repeat (40) send_random_pixel();
        setup(1'b1, 2'd3, 11'd1, 11'd1024);
        repeat (60) send_random_pixel();
        setup(1'b0, 2'd2, 11'd1, 11'd2047);
        repeat (40) send_random_pixel();
    endtask

    task automatic test_output_stall();
        setup(1'b0, 2'd1, 11'd6, 11'd5);
        hold_req = 1'b1;
        send_frame(0);
        wait_results();
        setup(1'b1, 2'd2, 11'd7, 11'd4);
        hold_req = 1'b1;
        send_frame(5);
    endtask

    task automatic test_random_frames();
        int sent;
        int w, h;
        sent = 0;
        while (sent < 200) begin
            calm = (sent < 60);
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            setup(1'($urandom), 2'($urandom), 11'(w), 11'(h));
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, w * h)) send_random_pixel();
            end else begin
                send_frame(8);
            end
            sent += w * h;
        end
        calm = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 400;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 36);
        end
    end

    always @(posedge aclk) begin
        filt_pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("Unexpected output beat: b=%0d g=%0d r=%0d end=%0b",
                             m_blue_out, m_green_out, m_red_out, m_frame_end);
            end else begin
                want = pending_pixels.pop_front();
                if (want.blue !== m_blue_out || want.green !== m_green_out
                        || want.red !== m_red_out || want.last !== m_frame_end) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("Mismatch: expected b=%0d g=%0d r=%0d end=%0b, got b=%0d g=%0d r=%0d end=%0b",
                                 want.blue, want.green, want.red, want.last,
                                 m_blue_out, m_green_out, m_red_out, m_frame_end);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL mean_median_window_filter");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_MODE;
        cfg_data = 11'd0;
        s_valid = 1'b0;
        s_operation = 1'b0;
        s_blue_in = 8'd0;
        s_green_in = 8'd0;
        s_red_in = 8'd0;
        mdl_mode = 1'b0;
        mdl_radius = 2'd1;
        mdl_width = 11'd640;
        mdl_height = 11'd480;
        foreach (pix_mem[i]) pix_mem[i] = 24'd0;
        clear_position();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_small();
        test_odd_registers();
        test_output_stall();
        test_random_frames();
        test_large_sizes();
        wait_results();
        if (pending_pixels.size() == 0 && error_count == 0) begin
            $display("PASS mean_median_window_filter");
        end else begin
            $display("FAIL mean_median_window_filter");
        end
        $finish;
    end
endmodule
